@@ hw/rtl/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg: shared definitions for the source text tokenizer
// Character codes, token kinds, scanner modes, controller states, the
// command and status bundles between controller and datapath, and the
// character classification functions.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int LEXEME_MAX_DEF = 32;
  localparam int CHAR_W         = 8;
  localparam int KIND_W         = 4;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_STRING = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_END      = 4'd0,
    KIND_IDENT    = 4'd1,
    KIND_FUNC     = 4'd2,
    KIND_NUMBER   = 4'd3,
    KIND_STRING   = 4'd4,
    KIND_ASSIGN   = 4'd5,
    KIND_LPAREN   = 4'd6,
    KIND_RPAREN   = 4'd7,
    KIND_LBRACE   = 4'd8,
    KIND_RBRACE   = 4'd9,
    KIND_COMMA    = 4'd10,
    KIND_OPERATOR = 4'd11
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_DRAIN = 2'd1,
    ST_SCAN  = 2'd2
  } state_t;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_ASSIGN = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

  localparam logic [4*CHAR_W-1:0] FUNC_WORD = "func";

  typedef struct packed {
    logic accept;
    logic drain_step;
    logic drain_run_last;
    logic scan_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic absorb;
    logic ends_string;
    logic mode_idle;
    logic scan_emits;
    logic drain_last;
    logic out_free;
  } dp_status_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
  endfunction

  function automatic logic [CHAR_W-1:0] func_char(input logic [1:0] pos);
    return FUNC_WORD[CHAR_W*(3-int'(pos)) +: CHAR_W];
  endfunction

  // True when a byte scanned in the idle mode yields a single result.
  function automatic logic scan_emits(input logic [CHAR_W-1:0] c);
    return !(is_space(c) || is_alpha(c) || is_digit(c) || (c == CH_QUOTE));
  endfunction

  function automatic kind_t scan_kind(input logic [CHAR_W-1:0] c);
    kind_t k;
    case (c) inside
      CH_ASSIGN:                             k = KIND_ASSIGN;
      CH_LPAREN:                             k = KIND_LPAREN;
      CH_RPAREN:                             k = KIND_RPAREN;
      CH_LBRACE:                             k = KIND_LBRACE;
      CH_RBRACE:                             k = KIND_RBRACE;
      CH_COMMA:                              k = KIND_COMMA;
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH:  k = KIND_OPERATOR;
      default:                               k = KIND_END;
    endcase
    return k;
  endfunction

endpackage

@@ hw/rtl/stt_ctrl.sv @@
// ----------------------------------------------------------------------------
// stt_ctrl: tokenizer controller
// Sequences byte intake, draining of the buffered lexeme and the idle-mode
// scan of a byte, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module stt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  stt_pkg::dp_status_t st,
  output stt_pkg::ctrl_cmd_t  cmd
);

  stt_pkg::state_t state_r, state_nxt;
  logic            rescan_r, rescan_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= stt_pkg::ST_IDLE;
      rescan_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rescan_r <= rescan_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rescan_nxt = rescan_r;
    unique case (state_r)
      stt_pkg::ST_IDLE: begin
        if (in_tvalid && !st.absorb) begin
          state_nxt  = st.mode_idle ? stt_pkg::ST_SCAN : stt_pkg::ST_DRAIN;
          rescan_nxt = !st.ends_string;
        end
      end
      stt_pkg::ST_DRAIN: begin
        if (st.out_free && st.drain_last) begin
          state_nxt = rescan_r ? stt_pkg::ST_SCAN : stt_pkg::ST_IDLE;
        end
      end
      stt_pkg::ST_SCAN: begin
        if (st.out_free || !st.scan_emits) begin
          state_nxt = stt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = stt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready          = 1'b0;
    cmd.accept         = 1'b0;
    cmd.drain_step     = 1'b0;
    cmd.drain_run_last = !(rescan_r && st.scan_emits);
    cmd.scan_step      = 1'b0;
    unique case (state_r)
      stt_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      stt_pkg::ST_DRAIN: begin
        cmd.drain_step = st.out_free;
      end
      stt_pkg::ST_SCAN: begin
        cmd.scan_step = st.out_free || !st.scan_emits;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  a_drain_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.drain_step && st.drain_last) |=> (state_r != stt_pkg::ST_DRAIN))
    else $error("controller stayed in drain after the last lexeme byte");

  a_scan_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |=> (state_r == stt_pkg::ST_IDLE))
    else $error("controller did not return to idle after a scan");

endmodule

@@ hw/rtl/stt_datapath.sv @@
// ----------------------------------------------------------------------------
// stt_datapath: tokenizer datapath
// Holds the scanner mode, the lexeme buffer with its length, overflow and
// keyword match flags, the saved byte, and the result output register.
// ----------------------------------------------------------------------------
module stt_datapath #(
  parameter int LEXEME_MAX = stt_pkg::LEXEME_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [stt_pkg::CHAR_W-1:0] in_char,
  input  stt_pkg::ctrl_cmd_t         cmd,
  output stt_pkg::dp_status_t        st,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [stt_pkg::KIND_W-1:0] token_kind,
  output logic [stt_pkg::CHAR_W-1:0] lexeme_byte,
  output logic                       byte_valid,
  output logic                       token_end,
  output logic                       run_last,
  output logic                       lexeme_truncated
);

  localparam int LW = $clog2(LEXEME_MAX + 1);
  localparam int AW = $clog2(LEXEME_MAX);
  localparam logic [LW-1:0] LEN_MAX  = LW'(LEXEME_MAX);
  localparam logic [LW-1:0] LEN_FUNC = LW'(4);

  logic [stt_pkg::CHAR_W-1:0] mem [LEXEME_MAX];
  logic [stt_pkg::CHAR_W-1:0] rdata_r;

  stt_pkg::mode_t             mode_r, mode_nxt;
  logic [LW-1:0]              len_r, len_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       func_r, func_nxt;
  logic [LW-1:0]              rd_idx_r, rd_idx_nxt;
  logic [stt_pkg::CHAR_W-1:0] char_r, char_nxt;

  logic                       app_en;
  logic [stt_pkg::CHAR_W-1:0] app_char;
  logic                       wr_en;

  logic                       scan_emit;
  stt_pkg::kind_t             scan_k;
  stt_pkg::kind_t             drain_k;

  logic                       out_valid_r, out_valid_nxt;
  logic [stt_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [stt_pkg::CHAR_W-1:0] byte_r, byte_nxt;
  logic                       bval_r, bval_nxt;
  logic                       tend_r, tend_nxt;
  logic                       rlast_r, rlast_nxt;
  logic                       trunc_r, trunc_nxt;

  always_comb begin
    st.absorb = 1'b0;
    unique case (mode_r)
      stt_pkg::MODE_IDENT:  st.absorb = stt_pkg::is_alpha(in_char) ||
                                        stt_pkg::is_digit(in_char);
      stt_pkg::MODE_NUMBER: st.absorb = stt_pkg::is_digit(in_char);
      stt_pkg::MODE_STRING: st.absorb = (in_char != stt_pkg::CH_QUOTE) &&
                                        (in_char != stt_pkg::CH_NUL);
      default:              st.absorb = 1'b0;
    endcase
    st.ends_string = (mode_r == stt_pkg::MODE_STRING) && (in_char == stt_pkg::CH_QUOTE);
    st.mode_idle   = (mode_r == stt_pkg::MODE_IDLE);
    st.scan_emits  = scan_emit;
    st.drain_last  = (len_r == '0) || ((rd_idx_r + LW'(1)) == len_r);
    st.out_free    = !out_valid_r || out_tready;
  end

  assign scan_emit = stt_pkg::scan_emits(char_r);
  assign scan_k    = stt_pkg::scan_kind(char_r);

  always_comb begin
    unique case (mode_r)
      stt_pkg::MODE_IDENT:  drain_k = (func_r && !ovf_r && (len_r == LEN_FUNC)) ?
                                      stt_pkg::KIND_FUNC : stt_pkg::KIND_IDENT;
      stt_pkg::MODE_NUMBER: drain_k = stt_pkg::KIND_NUMBER;
      stt_pkg::MODE_STRING: drain_k = stt_pkg::KIND_STRING;
      default:              drain_k = stt_pkg::KIND_END;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    char_nxt   = char_r;
    rd_idx_nxt = rd_idx_r;
    app_en     = 1'b0;
    app_char   = cmd.accept ? in_char : char_r;

    if (cmd.accept) begin
      char_nxt   = in_char;
      rd_idx_nxt = '0;
      app_en     = st.absorb;
    end

    if (cmd.scan_step) begin
      if (stt_pkg::is_alpha(char_r)) begin
        app_en   = 1'b1;
        mode_nxt = stt_pkg::MODE_IDENT;
      end else if (stt_pkg::is_digit(char_r)) begin
        app_en   = 1'b1;
        mode_nxt = stt_pkg::MODE_NUMBER;
      end else if (char_r == stt_pkg::CH_QUOTE) begin
        mode_nxt = stt_pkg::MODE_STRING;
      end
    end

    if (cmd.drain_step) begin
      if (st.drain_last) begin
        rd_idx_nxt = '0;
        mode_nxt   = stt_pkg::MODE_IDLE;
      end else begin
        rd_idx_nxt = rd_idx_r + LW'(1);
      end
    end
  end

  always_comb begin
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    func_nxt = func_r;
    wr_en    = 1'b0;
    if (app_en) begin
      if (len_r < LEN_MAX) begin
        wr_en   = 1'b1;
        len_nxt = len_r + LW'(1);
        if (len_r < LEN_FUNC) begin
          func_nxt = ((len_r == '0) || func_r) &&
                     (app_char == stt_pkg::func_char(len_r[1:0]));
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.drain_step && st.drain_last) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    bval_nxt      = bval_r;
    tend_nxt      = tend_r;
    rlast_nxt     = rlast_r;
    trunc_nxt     = trunc_r;
    if (cmd.drain_step) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = drain_k;
      bval_nxt      = (len_r != '0);
      byte_nxt      = (len_r != '0) ? rdata_r : '0;
      tend_nxt      = st.drain_last;
      rlast_nxt     = st.drain_last && cmd.drain_run_last;
      trunc_nxt     = ovf_r;
    end else if (cmd.scan_step && scan_emit) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = scan_k;
      bval_nxt      = (scan_k == stt_pkg::KIND_OPERATOR);
      byte_nxt      = (scan_k == stt_pkg::KIND_OPERATOR) ? char_r : '0;
      tend_nxt      = 1'b1;
      rlast_nxt     = 1'b1;
      trunc_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= stt_pkg::MODE_IDLE;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    char_r  <= char_nxt;
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    bval_r  <= bval_nxt;
    tend_r  <= tend_nxt;
    rlast_r <= rlast_nxt;
    trunc_r <= trunc_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[len_r[AW-1:0]] <= app_char;
    end
    rdata_r <= mem[rd_idx_nxt[AW-1:0]];
  end

  assign out_tvalid       = out_valid_r;
  assign token_kind       = kind_r;
  assign lexeme_byte      = byte_r;
  assign byte_valid       = bval_r;
  assign token_end        = tend_r;
  assign run_last         = rlast_r;
  assign lexeme_truncated = trunc_r;

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == stt_pkg::MODE_IDLE) |-> ((len_r == '0) && !ovf_r))
    else $error("lexeme buffer not empty in the idle mode");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (len_r == LEN_MAX))
    else $error("overflow flagged while the lexeme buffer is not full");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.drain_step && st.drain_last) |=> ((mode_r == stt_pkg::MODE_IDLE) && out_valid_r))
    else $error("final drain step did not clear the mode or load a result");

endmodule

@@ hw/rtl/source_text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexical analyzer
// Takes source text one byte per transfer and emits tokens, one result
// transfer per lexeme byte, with kind, end, truncation and run markers.
//
//   Channel  Direction  Payload
//   in_      slave      tdata[7:0] char_in
//   out_     master     tdata[7:0] lexeme_byte; tuser kind/valid/end/trunc;
//                       tlast run_last
//
// A byte absorbed into a pending lexeme is taken while the controller stays
// idle; a byte scanned in the idle mode passes intake, then the scan step.
// A token ending drains the lexeme buffer at one result per cycle while the
// output is free (a single result for an empty lexeme), set by the single read
// port of the buffer, then scans the terminating byte unless it ends a string.
// Reset clears the mode, length, overflow flag and output valid bit; no clearing pass runs.
// A stalled out_tready holds the controller in drain or scan; in_tready is
// high only while the controller waits for a byte.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
  parameter int LEXEME_MAX = stt_pkg::LEXEME_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] lexeme_byte
  output logic [6:0] out_tuser,  // [3:0] token_kind, [4] byte_valid, [5] token_end,
                                 // [6] lexeme_truncated
  output logic       out_tlast   // run_last
);

  stt_pkg::ctrl_cmd_t  cmd;
  stt_pkg::dp_status_t st;

  logic [stt_pkg::KIND_W-1:0] token_kind;
  logic                       byte_valid;
  logic                       token_end;
  logic                       lexeme_truncated;

  stt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  stt_datapath #(
    .LEXEME_MAX (LEXEME_MAX)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_char          (in_tdata),
    .cmd              (cmd),
    .st               (st),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .token_kind       (token_kind),
    .lexeme_byte      (out_tdata),
    .byte_valid       (byte_valid),
    .token_end        (token_end),
    .run_last         (out_tlast),
    .lexeme_truncated (lexeme_truncated)
  );

  assign out_tuser = {lexeme_truncated, token_end, byte_valid, token_kind};

endmodule

@@ tb/source_text_tokenizer_tb.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb: self-checking bench for the source text tokenizer
// Streams source bytes into the tokenizer and checks every result transfer
// against a scanner model kept in the bench. Directed text covers each token
// kind, empty and cut lexemes, the func keyword and NUL inside a string. A
// random part then mixes well-formed tokens with noise bytes. The sender runs
// in bursts with random gaps and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module source_text_tokenizer_tb;

  localparam int HALF_PERIOD   = 5;
  localparam int LEX_DEPTH     = stt_pkg::LEXEME_MAX_DEF;
  localparam int RANDOM_BYTES  = 100;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    stt_pkg::kind_t kind;
    logic [7:0]     lexeme_byte;
    logic           byte_valid;
    logic           token_end;
    logic           run_last;
    logic           truncated;
  } token_beat_t;

  typedef enum logic [1:0] {
    RX_STEADY   = 2'd0,
    RX_MOSTLY   = 2'd1,
    RX_SPARSE   = 2'd2,
    RX_PERIODIC = 2'd3
  } rx_style_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [6:0] out_tuser;
  logic       out_tlast;

  stt_pkg::mode_t scan_state = stt_pkg::MODE_IDLE;
  logic [7:0]     lex_buf [LEX_DEPTH];
  int unsigned    lex_len = 0;
  logic           lex_cut = 1'b0;

  token_beat_t expected_beats [$];
  token_beat_t step_beats [$];
  token_beat_t head_beat;

  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned source_bytes = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_cycle = 0;
  rx_style_t   stall_style = RX_STEADY;

  source_text_tokenizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic logic char_is_blank(input logic [7:0] c);
    return (c == stt_pkg::CH_SPACE) || (c >= stt_pkg::CH_TAB && c <= stt_pkg::CH_CR);
  endfunction

  function automatic logic char_is_digit(input logic [7:0] c);
    return c >= stt_pkg::CH_ZERO && c <= stt_pkg::CH_NINE;
  endfunction

  function automatic logic char_is_letter(input logic [7:0] c);
    return (c >= stt_pkg::CH_UP_A && c <= stt_pkg::CH_UP_Z) ||
           (c >= stt_pkg::CH_LO_A && c <= stt_pkg::CH_LO_Z);
  endfunction

  function automatic logic [7:0] letter_pick();
    return ($urandom_range(0, 1) == 0) ? stt_pkg::CH_UP_A + 8'($urandom_range(0, 25))
                                       : stt_pkg::CH_LO_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] digit_pick();
    return stt_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] punct_pick();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0:       c = stt_pkg::CH_ASSIGN;
      1:       c = stt_pkg::CH_LPAREN;
      2:       c = stt_pkg::CH_RPAREN;
      3:       c = stt_pkg::CH_LBRACE;
      4:       c = stt_pkg::CH_RBRACE;
      5:       c = stt_pkg::CH_COMMA;
      6:       c = stt_pkg::CH_PLUS;
      7:       c = stt_pkg::CH_MINUS;
      8:       c = stt_pkg::CH_STAR;
      default: c = stt_pkg::CH_SLASH;
    endcase
    return c;
  endfunction

  task automatic push_beat(input stt_pkg::kind_t k, input logic [7:0] b, input logic v,
                           input logic e, input logic t);
    token_beat_t beat;
    beat.kind        = k;
    beat.lexeme_byte = b;
    beat.byte_valid  = v;
    beat.token_end   = e;
    beat.run_last    = 1'b0;
    beat.truncated   = t;
    step_beats.push_back(beat);
  endtask

  task automatic lex_append(input logic [7:0] c);
    if (lex_len < LEX_DEPTH) begin
      lex_buf[lex_len] = c;
      lex_len++;
    end else begin
      lex_cut = 1'b1;
    end
  endtask

  task automatic flush_lexeme(input stt_pkg::kind_t k);
    stt_pkg::kind_t kind;
    kind = k;
    if (kind == stt_pkg::KIND_IDENT && !lex_cut && lex_len == 4 &&
        {lex_buf[0], lex_buf[1], lex_buf[2], lex_buf[3]} == stt_pkg::FUNC_WORD) begin
      kind = stt_pkg::KIND_FUNC;
    end
    if (lex_len == 0) begin
      push_beat(kind, 8'h00, 1'b0, 1'b1, lex_cut);
    end else begin
      for (int i = 0; i < lex_len; i++) begin
        push_beat(kind, lex_buf[i], 1'b1, (i + 1 == lex_len), lex_cut);
      end
    end
    lex_len    = 0;
    lex_cut    = 1'b0;
    scan_state = stt_pkg::MODE_IDLE;
  endtask

  task automatic scan_fresh(input logic [7:0] c);
    if (c == stt_pkg::CH_NUL) begin
      push_beat(stt_pkg::KIND_END, 8'h00, 1'b0, 1'b1, 1'b0);
      scan_state = stt_pkg::MODE_IDLE;
      lex_len    = 0;
      lex_cut    = 1'b0;
    end else if (char_is_blank(c)) begin
    end else if (char_is_letter(c)) begin
      lex_len = 0;
      lex_cut = 1'b0;
      lex_append(c);
      scan_state = stt_pkg::MODE_IDENT;
    end else if (char_is_digit(c)) begin
      lex_len = 0;
      lex_cut = 1'b0;
      lex_append(c);
      scan_state = stt_pkg::MODE_NUMBER;
    end else if (c == stt_pkg::CH_QUOTE) begin
      lex_len    = 0;
      lex_cut    = 1'b0;
      scan_state = stt_pkg::MODE_STRING;
    end else begin
      case (c)
        stt_pkg::CH_ASSIGN: push_beat(stt_pkg::KIND_ASSIGN, 8'h00, 1'b0, 1'b1, 1'b0);
        stt_pkg::CH_LPAREN: push_beat(stt_pkg::KIND_LPAREN, 8'h00, 1'b0, 1'b1, 1'b0);
        stt_pkg::CH_RPAREN: push_beat(stt_pkg::KIND_RPAREN, 8'h00, 1'b0, 1'b1, 1'b0);
        stt_pkg::CH_LBRACE: push_beat(stt_pkg::KIND_LBRACE, 8'h00, 1'b0, 1'b1, 1'b0);
        stt_pkg::CH_RBRACE: push_beat(stt_pkg::KIND_RBRACE, 8'h00, 1'b0, 1'b1, 1'b0);
        stt_pkg::CH_COMMA:  push_beat(stt_pkg::KIND_COMMA, 8'h00, 1'b0, 1'b1, 1'b0);
        stt_pkg::CH_PLUS, stt_pkg::CH_MINUS, stt_pkg::CH_STAR, stt_pkg::CH_SLASH: begin
          push_beat(stt_pkg::KIND_OPERATOR, c, 1'b1, 1'b1, 1'b0);
        end
        default:            push_beat(stt_pkg::KIND_END, 8'h00, 1'b0, 1'b1, 1'b0);
      endcase
    end
  endtask

  task automatic predict_tokens(input logic [7:0] c);
    step_beats.delete();
    case (scan_state)
      stt_pkg::MODE_IDENT: begin
        if (char_is_letter(c) || char_is_digit(c)) begin
          lex_append(c);
        end else begin
          flush_lexeme(stt_pkg::KIND_IDENT);
          scan_fresh(c);
        end
      end
      stt_pkg::MODE_NUMBER: begin
        if (char_is_digit(c)) begin
          lex_append(c);
        end else begin
          flush_lexeme(stt_pkg::KIND_NUMBER);
          scan_fresh(c);
        end
      end
      stt_pkg::MODE_STRING: begin
        if (c == stt_pkg::CH_QUOTE) begin
          flush_lexeme(stt_pkg::KIND_STRING);
        end else if (c == stt_pkg::CH_NUL) begin
          flush_lexeme(stt_pkg::KIND_STRING);
          scan_fresh(c);
        end else begin
          lex_append(c);
        end
      end
      default: scan_fresh(c);
    endcase
    for (int i = 0; i < step_beats.size(); i++) begin
      if (i + 1 == step_beats.size()) begin
        step_beats[i].run_last = 1'b1;
      end
      expected_beats.push_back(step_beats[i]);
    end
  endtask

  task automatic send_byte(input logic [7:0] c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    source_bytes++;
    predict_tokens(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  task automatic wait_until_drained();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_tokens();
    send_text("func f1=(a,9){x+-*/}");
    send_text("\"\"");
    send_byte(8'hFF);
    send_text("\"q");
    send_byte(stt_pkg::CH_NUL);
  endtask

  task automatic test_long_lexemes();
    send_text("func");
    repeat (29) send_byte(letter_pick());
    send_byte(stt_pkg::CH_SPACE);
    repeat (LEX_DEPTH) send_byte(stt_pkg::CH_LO_A);
    send_byte(stt_pkg::CH_COMMA);
    repeat (40) send_byte(digit_pick());
    send_byte(stt_pkg::CH_RPAREN);
    send_byte(stt_pkg::CH_QUOTE);
    repeat (34) send_byte(letter_pick());
    send_byte(stt_pkg::CH_QUOTE);
  endtask

  task automatic test_quiet_input();
    wait_until_drained();
  endtask

  task automatic send_random_token();
    int unsigned pick;
    int unsigned span;
    logic [7:0]  ch;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      span = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
      if ($urandom_range(0, 7) == 0) begin
        send_text("func");
        span = $urandom_range(0, 2);
      end else begin
        send_byte(letter_pick());
        span--;
      end
      repeat (span) send_byte(($urandom_range(0, 2) == 0) ? digit_pick() : letter_pick());
      if ($urandom_range(0, 1) == 0) begin
        send_byte(stt_pkg::CH_SPACE);
      end
    end else if (pick < 40) begin
      span = ($urandom_range(0, 19) == 0) ? $urandom_range(31, 36) : $urandom_range(1, 8);
      repeat (span) send_byte(digit_pick());
      if ($urandom_range(0, 1) == 0) begin
        send_byte(stt_pkg::CH_SPACE);
      end
    end else if (pick < 52) begin
      span = ($urandom_range(0, 19) == 0) ? $urandom_range(31, 36) : $urandom_range(0, 10);
      send_byte(stt_pkg::CH_QUOTE);
      repeat (span) begin
        ch = 8'($urandom_range(1, 255));
        if (ch == stt_pkg::CH_QUOTE) begin
          ch = stt_pkg::CH_SPACE;
        end
        send_byte(ch);
      end
      send_byte(($urandom_range(0, 6) == 0) ? stt_pkg::CH_NUL : stt_pkg::CH_QUOTE);
    end else if (pick < 74) begin
      send_byte(punct_pick());
    end else if (pick < 84) begin
      send_byte(($urandom_range(0, 2) == 0) ? stt_pkg::CH_SPACE : 8'($urandom_range(9, 13)));
    end else if (pick < 95) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(stt_pkg::CH_NUL);
    end
  endtask

  task automatic test_random_source();
    source_bytes = 0;
    while (source_bytes < RANDOM_BYTES) send_random_token();
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 64 == 0) begin
      stall_style <= rx_style_t'($urandom_range(0, 3));
    end
    case (stall_style)
      RX_STEADY:   out_tready <= 1'b1;
      RX_MOSTLY:   out_tready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE:   out_tready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: out_tready <= (stall_cycle % 8 != 5) && (stall_cycle % 8 != 6);
      default:     out_tready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        $error("result transfer with nothing expected: tdata %0h tuser %0h tlast %0b",
               out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        head_beat = expected_beats.pop_front();
        check_field("token_kind", 8'(head_beat.kind), 8'(out_tuser[3:0]));
        check_field("lexeme_byte", head_beat.lexeme_byte, out_tdata);
        check_field("byte_valid", 8'(head_beat.byte_valid), 8'(out_tuser[4]));
        check_field("token_end", 8'(head_beat.token_end), 8'(out_tuser[5]));
        check_field("run_last", 8'(head_beat.run_last), 8'(out_tlast));
        check_field("lexeme_truncated", 8'(head_beat.truncated), 8'(out_tuser[6]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_tokens();
    test_long_lexemes();
    test_quiet_input();
    test_random_source();
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
